@@ hw/rtl/mraa_pkg.sv @@
// shared types, codes and helpers of the admission allocator
package mraa_pkg;

    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;
    localparam int CFG_DW  = 16;
    localparam int HELD_W  = 7;

    localparam logic [9:0]  RST_TOTAL_CPU  = 10'd64;
    localparam logic [15:0] RST_TOTAL_RAM  = 16'd256;
    localparam logic [9:0]  RST_TOTAL_DISK = 10'd64;
    localparam logic [9:0]  RST_TOTAL_NET  = 10'd64;

    typedef enum logic [1:0] {
        CMD_CHECK   = 2'd0,
        CMD_ALLOC   = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_QUERY   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_FULL      = 3'd2,
        ST_RELEASED  = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_QUERY     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        REG_TOTAL_CPU  = 2'd0,
        REG_TOTAL_RAM  = 2'd1,
        REG_TOTAL_DISK = 2'd2,
        REG_TOTAL_NET  = 2'd3
    } t_reg;

    typedef struct packed {
        t_cmd        command;
        logic [15:0] job_id;
        logic [9:0]  cpu_req;
        logic [15:0] ram_req;
        logic [9:0]  disk_req;
        logic [9:0]  net_req;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [9:0]  avail_cpu;
        logic [15:0] avail_ram;
        logic [9:0]  avail_disk;
        logic [9:0]  avail_net;
        logic [6:0]  grants_held;
    } t_out_item;

    typedef struct packed {
        logic [15:0] job;
        logic [9:0]  cpu;
        logic [15:0] ram;
        logic [9:0]  disk;
        logic [9:0]  net;
    } t_grant;

    typedef struct packed {
        logic              wr_en;
        t_reg              idx;
        logic [CFG_DW-1:0] data;
    } t_cfg_wr;

    function automatic logic [9:0] sat_add10(input logic [9:0] a, input logic [9:0] b);
        logic [10:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[10] ? 10'h3FF : s[9:0];
    endfunction

    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

endpackage

@@ hw/rtl/mraa_ram.sv @@
// generic single-write single-read ram with registered read data
module mraa_ram #(
    parameter int WIDTH = 62,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/mraa_engine.sv @@
// command sequencer, free counters and grant table of the allocator
module mraa_engine #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mraa_pkg::t_cfg_wr   i_cfg,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mraa_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mraa_pkg::t_out_item o_out_item
);
    import mraa_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = IW + 1;
    localparam int GW = $bits(t_grant);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state      r_state, n_state;
    t_in_item    r_item, n_item;
    logic [9:0]  r_free_cpu, n_free_cpu;
    logic [15:0] r_free_ram, n_free_ram;
    logic [9:0]  r_free_disk, n_free_disk;
    logic [9:0]  r_free_net, n_free_net;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_idx, n_idx;
    t_status     r_status, n_status;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    logic          w_rd_en;
    logic [IW-1:0] w_rd_addr;
    logic          w_wr_en;
    logic [IW-1:0] w_wr_addr;
    t_grant        w_wr_data;
    logic [GW-1:0] w_rd_raw;
    t_grant        w_rd_grant;
    logic          w_fits;
    logic [CW-1:0] w_idx_next;
    logic          w_more;
    logic          w_hit;

    mraa_ram #(
        .WIDTH (GW),
        .DEPTH (TABLE_ENTRIES),
        .AW    (IW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_raw)
    );

    assign w_rd_grant = t_grant'(w_rd_raw);
    assign w_fits     = (r_item.cpu_req <= r_free_cpu) && (r_item.ram_req <= r_free_ram) &&
                        (r_item.disk_req <= r_free_disk) && (r_item.net_req <= r_free_net);
    assign w_idx_next = {1'b0, r_idx} + CW'(1);
    assign w_more     = w_idx_next < r_count;
    assign w_hit      = w_rd_grant.job == r_item.job_id;

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_free_cpu  = r_free_cpu;
        n_free_ram  = r_free_ram;
        n_free_disk = r_free_disk;
        n_free_net  = r_free_net;
        n_count     = r_count;
        n_idx       = r_idx;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_rd_en     = 1'b0;
        w_rd_addr   = '0;
        w_wr_en     = 1'b0;
        w_wr_addr   = '0;
        w_wr_data   = w_rd_grant;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_DONE;
                unique case (r_item.command)
                    CMD_CHECK: begin
                        n_status = w_fits ? ST_OK : ST_SHORT;
                    end
                    CMD_ALLOC: begin
                        if (!w_fits) begin
                            n_status = ST_SHORT;
                        end else if (r_count >= CW'(TABLE_ENTRIES)) begin
                            n_status = ST_FULL;
                        end else begin
                            w_wr_en        = 1'b1;
                            w_wr_addr      = r_count[IW-1:0];
                            w_wr_data.job  = r_item.job_id;
                            w_wr_data.cpu  = r_item.cpu_req;
                            w_wr_data.ram  = r_item.ram_req;
                            w_wr_data.disk = r_item.disk_req;
                            w_wr_data.net  = r_item.net_req;
                            n_free_cpu     = r_free_cpu - r_item.cpu_req;
                            n_free_ram     = r_free_ram - r_item.ram_req;
                            n_free_disk    = r_free_disk - r_item.disk_req;
                            n_free_net     = r_free_net - r_item.net_req;
                            n_count        = r_count + CW'(1);
                            n_status       = ST_OK;
                        end
                    end
                    CMD_RELEASE: begin
                        if (r_count == '0) begin
                            n_status = ST_NOT_FOUND;
                        end else begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = '0;
                            n_idx     = '0;
                            n_state   = S_SCAN;
                        end
                    end
                    CMD_QUERY: begin
                        n_status = ST_QUERY;
                    end
                    default: begin
                        n_status = ST_QUERY;
                    end
                endcase
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_free_cpu  = sat_add10(r_free_cpu, w_rd_grant.cpu);
                    n_free_ram  = sat_add16(r_free_ram, w_rd_grant.ram);
                    n_free_disk = sat_add10(r_free_disk, w_rd_grant.disk);
                    n_free_net  = sat_add10(r_free_net, w_rd_grant.net);
                    if (w_more) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_idx_next[IW-1:0];
                        n_idx     = w_idx_next[IW-1:0];
                        n_state   = S_SHIFT;
                    end else begin
                        n_count  = r_count - CW'(1);
                        n_status = ST_RELEASED;
                        n_state  = S_DONE;
                    end
                end else if (w_more) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_idx_next[IW-1:0];
                    n_idx     = w_idx_next[IW-1:0];
                end else begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end
            end
            S_SHIFT: begin
                // move entry down one slot to close the gap
                w_wr_en   = 1'b1;
                w_wr_addr = r_idx - IW'(1);
                w_wr_data = w_rd_grant;
                if (w_more) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_idx_next[IW-1:0];
                    n_idx     = w_idx_next[IW-1:0];
                end else begin
                    n_count  = r_count - CW'(1);
                    n_status = ST_RELEASED;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = r_status;
                    n_out.avail_cpu   = r_free_cpu;
                    n_out.avail_ram   = r_free_ram;
                    n_out.avail_disk  = r_free_disk;
                    n_out.avail_net   = r_free_net;
                    n_out.grants_held = HELD_W'(r_count);
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg.wr_en) begin
            unique case (i_cfg.idx)
                REG_TOTAL_CPU:  n_free_cpu  = i_cfg.data[9:0];
                REG_TOTAL_RAM:  n_free_ram  = i_cfg.data[15:0];
                REG_TOTAL_DISK: n_free_disk = i_cfg.data[9:0];
                REG_TOTAL_NET:  n_free_net  = i_cfg.data[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_cpu  <= RST_TOTAL_CPU;
            r_free_ram  <= RST_TOTAL_RAM;
            r_free_disk <= RST_TOTAL_DISK;
            r_free_net  <= RST_TOTAL_NET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_cpu  <= n_free_cpu;
            r_free_ram  <= n_free_ram;
            r_free_disk <= n_free_disk;
            r_free_net  <= n_free_net;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_item   <= n_item;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ENTRIES))
        else $error("grant count beyond table size");

    a_wr_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> ({1'b0, w_wr_addr} <= r_count))
        else $error("table write outside held entries");

    a_shift_above_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_idx != '0))
        else $error("compaction would write below entry zero");

    a_grant_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && r_item.command == CMD_ALLOC && n_status == ST_OK)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("granted allocate did not add an entry");

endmodule

@@ hw/rtl/multi_resource_admission_allocator_core.sv @@
// top level: apb register file for the totals and the allocator engine
//
// Each command takes one item and returns one item. Check, allocate and query
// pass from the evaluate state through the done state into the output
// register; the done state waits while that register holds an untaken result.
// Release walks the grant table oldest first, one entry per cycle through the
// single read port of the table memory, then moves every younger entry down
// one slot, also one per cycle, so the walk covers every held entry whether or
// not the job is found. A new item is accepted as soon as the engine is back
// at rest, even while the previous result still waits in the output register.
// Writing a total through the register port reloads the matching available
// count; grants already held stay in the table.
module multi_resource_admission_allocator_core #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  mraa_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output mraa_pkg::t_out_item         o_out_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mraa_pkg::APB_AW-1:0] paddr,
    input  logic [mraa_pkg::APB_DW-1:0] pwdata,
    output logic [mraa_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import mraa_pkg::*;

    logic [9:0]  r_total_cpu;
    logic [15:0] r_total_ram;
    logic [9:0]  r_total_disk;
    logic [9:0]  r_total_net;
    t_reg        w_reg;
    t_cfg_wr     w_cfg;

    assign w_reg        = t_reg'(paddr[3:2]);
    assign w_cfg.wr_en  = psel && penable && pwrite;
    assign w_cfg.idx    = w_reg;
    assign w_cfg.data   = pwdata[CFG_DW-1:0];
    assign pready       = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_cpu  <= RST_TOTAL_CPU;
            r_total_ram  <= RST_TOTAL_RAM;
            r_total_disk <= RST_TOTAL_DISK;
            r_total_net  <= RST_TOTAL_NET;
        end else if (w_cfg.wr_en) begin
            unique case (w_reg)
                REG_TOTAL_CPU:  r_total_cpu  <= pwdata[9:0];
                REG_TOTAL_RAM:  r_total_ram  <= pwdata[15:0];
                REG_TOTAL_DISK: r_total_disk <= pwdata[9:0];
                REG_TOTAL_NET:  r_total_net  <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_TOTAL_CPU:  prdata = APB_DW'(r_total_cpu);
            REG_TOTAL_RAM:  prdata = APB_DW'(r_total_ram);
            REG_TOTAL_DISK: prdata = APB_DW'(r_total_disk);
            REG_TOTAL_NET:  prdata = APB_DW'(r_total_net);
            default:        prdata = '0;
        endcase
    end

    mraa_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

@@ tb/sv/multi_resource_admission_allocator_core_tb.sv @@
// testbench of the admission allocator: random and directed commands checked against a grant table model
`timescale 1ns / 1ps
module multi_resource_admission_allocator_core_tb;
    import mraa_pkg::*;

    localparam int TBL_DEPTH   = 64;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 100;
    localparam int MAX_PRINTS  = 40;
    localparam int JOB_POOL_N  = 12;
    localparam int CNT10_MAX   = 1023;
    localparam int CNT16_MAX   = 65535;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_in_item          i_in_item   = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_item         o_out_item;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [APB_AW-1:0] paddr       = '0;
    logic [APB_DW-1:0] pwdata      = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    logic [9:0]  free_cpu  = 10'd64;
    logic [15:0] free_ram  = 16'd256;
    logic [9:0]  free_disk = 10'd64;
    logic [9:0]  free_net  = 10'd64;
    t_grant      held_grants[$];
    t_out_item   replies_due[$];
    logic [15:0] job_pool[JOB_POOL_N];

    int mismatches      = 0;
    int items_sent      = 0;
    int replies_checked = 0;
    int cfg_writes      = 0;
    int peak_held       = 0;
    int status_hits[6]  = '{default: 0};
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int stall_cycles    = 0;

    multi_resource_admission_allocator_core #(
        .TABLE_ENTRIES(TBL_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("%0t ns mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    function automatic logic [15:0] add_capped(input int unsigned a, input int unsigned b,
                                               input int unsigned cap);
        if (a + b > cap) begin
            return 16'(cap);
        end
        return 16'(a + b);
    endfunction

    function automatic t_out_item admit_and_account(input t_in_item it);
        t_out_item r;
        t_grant    g;
        logic      fits;
        int        hit;
        fits = (it.cpu_req <= free_cpu) && (it.ram_req <= free_ram) &&
               (it.disk_req <= free_disk) && (it.net_req <= free_net);
        hit = -1;
        r = '0;
        case (it.command)
            CMD_CHECK: begin
                if (fits) r.status = ST_OK;
                else r.status = ST_SHORT;
            end
            CMD_ALLOC: begin
                if (!fits) begin
                    r.status = ST_SHORT;
                end else if (held_grants.size() >= TBL_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    free_cpu  -= it.cpu_req;
                    free_ram  -= it.ram_req;
                    free_disk -= it.disk_req;
                    free_net  -= it.net_req;
                    g.job  = it.job_id;
                    g.cpu  = it.cpu_req;
                    g.ram  = it.ram_req;
                    g.disk = it.disk_req;
                    g.net  = it.net_req;
                    held_grants.insert(held_grants.size(), g);
                    r.status = ST_OK;
                end
            end
            CMD_RELEASE: begin
                for (int i = 0; i < held_grants.size(); i++) begin
                    if (hit < 0 && held_grants[i].job == it.job_id) hit = i;
                end
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    free_cpu  = 10'(add_capped(free_cpu, held_grants[hit].cpu, CNT10_MAX));
                    free_ram  = add_capped(free_ram, held_grants[hit].ram, CNT16_MAX);
                    free_disk = 10'(add_capped(free_disk, held_grants[hit].disk, CNT10_MAX));
                    free_net  = 10'(add_capped(free_net, held_grants[hit].net, CNT10_MAX));
                    held_grants.delete(hit);
                    r.status = ST_RELEASED;
                end
            end
            default: r.status = ST_QUERY;
        endcase
        r.avail_cpu   = free_cpu;
        r.avail_ram   = free_ram;
        r.avail_disk  = free_disk;
        r.avail_net   = free_net;
        r.grants_held = 7'(held_grants.size());
        status_hits[r.status]++;
        if (held_grants.size() > peak_held) peak_held = held_grants.size();
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (replies_due.size() == 0) begin
                report_mismatch("reply with none due", o_out_item.status, 0);
            end else begin
                want = replies_due.pop_front();
                replies_checked++;
                if (o_out_item.status !== want.status)
                    report_mismatch("status", o_out_item.status, want.status);
                if (o_out_item.avail_cpu !== want.avail_cpu)
                    report_mismatch("avail_cpu", o_out_item.avail_cpu, want.avail_cpu);
                if (o_out_item.avail_ram !== want.avail_ram)
                    report_mismatch("avail_ram", o_out_item.avail_ram, want.avail_ram);
                if (o_out_item.avail_disk !== want.avail_disk)
                    report_mismatch("avail_disk", o_out_item.avail_disk, want.avail_disk);
                if (o_out_item.avail_net !== want.avail_net)
                    report_mismatch("avail_net", o_out_item.avail_net, want.avail_net);
                if (o_out_item.grants_held !== want.grants_held)
                    report_mismatch("grants_held", o_out_item.grants_held, want.grants_held);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("no handshake for %0d cycles, run stopped", STALL_LIMIT);
            $display("[multi_resource_admission_allocator_core] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_command(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        replies_due.insert(replies_due.size(), admit_and_account(it));
        items_sent++;
    endtask

    task automatic wait_replies_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (replies_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_total(input t_reg which, input logic [31:0] value);
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (which)
            REG_TOTAL_CPU: begin
                free_cpu = value[9:0];
                want = 32'(value[9:0]);
            end
            REG_TOTAL_RAM: begin
                free_ram = value[15:0];
                want = 32'(value[15:0]);
            end
            REG_TOTAL_DISK: begin
                free_disk = value[9:0];
                want = 32'(value[9:0]);
            end
            default: begin
                free_net = value[9:0];
                want = 32'(value[9:0]);
            end
        endcase
        cfg_writes++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) report_mismatch("register readback", prdata, want);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_all_totals(input logic [31:0] cpu, input logic [31:0] ram,
                                  input logic [31:0] disk, input logic [31:0] net);
        set_total(REG_TOTAL_CPU, cpu);
        set_total(REG_TOTAL_RAM, ram);
        set_total(REG_TOTAL_DISK, disk);
        set_total(REG_TOTAL_NET, net);
    endtask

    function automatic t_in_item make_item(input t_cmd cmd, input logic [15:0] job,
                                           input logic [9:0] cpu, input logic [15:0] ram,
                                           input logic [9:0] disk, input logic [9:0] net);
        t_in_item it;
        it.command  = cmd;
        it.job_id   = job;
        it.cpu_req  = cpu;
        it.ram_req  = ram;
        it.disk_req = disk;
        it.net_req  = net;
        return it;
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int       pick;
        it = t_in_item'({$urandom(), $urandom()});
        pick = $urandom_range(99);
        if (pick < 15) it.command = CMD_CHECK;
        else if (pick < 50) it.command = CMD_ALLOC;
        else if (pick < 85) it.command = CMD_RELEASE;
        else it.command = CMD_QUERY;
        if (it.command == CMD_RELEASE && held_grants.size() != 0 && $urandom_range(99) < 80) begin
            it.job_id = held_grants[$urandom_range(held_grants.size() - 1)].job;
        end else if ($urandom_range(99) < 70) begin
            it.job_id = job_pool[$urandom_range(JOB_POOL_N - 1)];
        end
        pick = $urandom_range(99);
        if (pick < 10) begin
            it.cpu_req  = free_cpu;
            it.ram_req  = free_ram;
            it.disk_req = free_disk;
            it.net_req  = free_net;
        end else if (pick < 75) begin
            it.cpu_req  = 10'($urandom_range(free_cpu / 6));
            it.ram_req  = 16'($urandom_range(free_ram / 6));
            it.disk_req = 10'($urandom_range(free_disk / 6));
            it.net_req  = 10'($urandom_range(free_net / 6));
        end
        return it;
    endfunction

    function automatic logic [31:0] random_total(input int unsigned cap);
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) return cap;
        if (pick < 25) return 0;
        if (pick < 40) return $urandom();
        return $urandom_range(cap, cap / 8);
    endfunction

    task automatic test_reset_directed();
        send_command(make_item(CMD_QUERY, 16'h0000, 10'd0, 16'd0, 10'd0, 10'd0));
        send_command(make_item(CMD_CHECK, 16'h0000, 10'd0, 16'd0, 10'd0, 10'd0));
        send_command(make_item(CMD_CHECK, 16'h1234, 10'd64, 16'd256, 10'd64, 10'd64));
        send_command(make_item(CMD_CHECK, 16'h0001, 10'd65, 16'd0, 10'd0, 10'd0));
        send_command(make_item(CMD_CHECK, 16'h0001, 10'd0, 16'd257, 10'd0, 10'd0));
        send_command(make_item(CMD_CHECK, 16'h0001, 10'd0, 16'd0, 10'd65, 10'd0));
        send_command(make_item(CMD_CHECK, 16'h0001, 10'd0, 16'd0, 10'd0, 10'd65));
        send_command(make_item(CMD_CHECK, 16'hFFFF, 10'h3FF, 16'hFFFF, 10'h3FF, 10'h3FF));
        send_command(make_item(CMD_RELEASE, 16'h0000, 10'd0, 16'd0, 10'd0, 10'd0));
        send_command(make_item(CMD_ALLOC, 16'hFFFF, 10'd64, 16'd256, 10'd64, 10'd64));
        send_command(make_item(CMD_ALLOC, 16'h0001, 10'd0, 16'd0, 10'd0, 10'd0));
        send_command(make_item(CMD_ALLOC, 16'h0002, 10'd1, 16'd0, 10'd0, 10'd0));
        send_command(make_item(CMD_RELEASE, 16'hFFFF, 10'h3FF, 16'hFFFF, 10'h3FF, 10'h3FF));
        send_command(make_item(CMD_ALLOC, 16'h0005, 10'd10, 16'd20, 10'd3, 10'd4));
        send_command(make_item(CMD_ALLOC, 16'h0005, 10'd1, 16'd2, 10'd3, 10'd4));
        send_command(make_item(CMD_ALLOC, 16'h0007, 10'd5, 16'd5, 10'd5, 10'd5));
        send_command(make_item(CMD_RELEASE, 16'h0005, 10'd0, 16'd0, 10'd0, 10'd0));
        send_command(make_item(CMD_RELEASE, 16'h0005, 10'd0, 16'd0, 10'd0, 10'd0));
        send_command(make_item(CMD_RELEASE, 16'h0005, 10'd0, 16'd0, 10'd0, 10'd0));
        send_command(make_item(CMD_RELEASE, 16'h0001, 10'd0, 16'd0, 10'd0, 10'd0));
        send_command(make_item(CMD_QUERY, 16'hFFFF, 10'h3FF, 16'hFFFF, 10'h3FF, 10'h3FF));
    endtask

    task automatic test_table_fill();
        wait_replies_drained();
        set_all_totals(CNT10_MAX, CNT16_MAX, CNT10_MAX, CNT10_MAX);
        while (held_grants.size() < TBL_DEPTH) begin
            send_command(make_item(CMD_ALLOC, job_pool[$urandom_range(JOB_POOL_N - 1)],
                                   10'($urandom_range(15)), 16'($urandom_range(1023)),
                                   10'($urandom_range(15)), 10'($urandom_range(15))));
        end
        send_command(make_item(CMD_ALLOC, 16'h4321, 10'd0, 16'd0, 10'd0, 10'd0));
        send_command(make_item(CMD_ALLOC, 16'h4321, 10'h3FF, 16'd0, 10'd0, 10'd0));
        send_command(make_item(CMD_CHECK, 16'h4321, 10'd1, 16'd1, 10'd1, 10'd1));
        send_command(make_item(CMD_QUERY, 16'h4321, 10'd0, 16'd0, 10'd0, 10'd0));
        repeat (40) begin
            if ($urandom_range(1) == 1 && held_grants.size() != 0) begin
                send_command(make_item(CMD_RELEASE,
                                       held_grants[$urandom_range(held_grants.size() - 1)].job,
                                       10'($urandom()), 16'($urandom()),
                                       10'($urandom()), 10'($urandom())));
            end else begin
                send_command(make_item(CMD_ALLOC, job_pool[$urandom_range(JOB_POOL_N - 1)],
                                       10'($urandom_range(15)), 16'($urandom_range(1023)),
                                       10'($urandom_range(15)), 10'($urandom_range(15))));
            end
        end
        while (held_grants.size() != 0) begin
            send_command(make_item(CMD_RELEASE,
                                   held_grants[$urandom_range(held_grants.size() - 1)].job,
                                   10'd0, 16'd0, 10'd0, 10'd0));
        end
        send_command(make_item(CMD_RELEASE, job_pool[0], 10'd0, 16'd0, 10'd0, 10'd0));
    endtask

    task automatic test_totals_rewrite();
        wait_replies_drained();
        set_all_totals(CNT10_MAX, CNT16_MAX, CNT10_MAX, CNT10_MAX);
        while (held_grants.size() != 0) begin
            send_command(make_item(CMD_RELEASE, held_grants[0].job, 10'd0, 16'd0, 10'd0, 10'd0));
        end
        send_command(make_item(CMD_ALLOC, 16'h00AA, 10'd1000, 16'd60000, 10'd1000, 10'd1000));
        wait_replies_drained();
        set_all_totals(CNT10_MAX, CNT16_MAX, CNT10_MAX, CNT10_MAX);
        send_command(make_item(CMD_RELEASE, 16'h00AA, 10'd0, 16'd0, 10'd0, 10'd0));
        send_command(make_item(CMD_ALLOC, 16'h00BB, 10'd3, 16'd3, 10'd3, 10'd3));
        wait_replies_drained();
        set_all_totals(32'hFFFF_FC00, 32'd0, 32'd0, 32'd0);
        send_command(make_item(CMD_CHECK, 16'h00BB, 10'd0, 16'd0, 10'd0, 10'd0));
        send_command(make_item(CMD_CHECK, 16'h00BB, 10'd1, 16'd0, 10'd0, 10'd0));
        send_command(make_item(CMD_ALLOC, 16'h00CC, 10'd0, 16'd0, 10'd0, 10'd0));
        send_command(make_item(CMD_RELEASE, 16'h00BB, 10'd0, 16'd0, 10'd0, 10'd0));
        send_command(make_item(CMD_RELEASE, 16'h00CC, 10'd0, 16'd0, 10'd0, 10'd0));
        send_command(make_item(CMD_QUERY, 16'h0000, 10'd0, 16'd0, 10'd0, 10'd0));
    endtask

    task automatic test_random_mix(input int count);
        wait_replies_drained();
        set_all_totals(random_total(CNT10_MAX), random_total(CNT16_MAX),
                       random_total(CNT10_MAX), random_total(CNT10_MAX));
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) wait_replies_drained();
            send_command(random_item());
        end
    endtask

    initial begin
        job_pool[0] = 16'h0000;
        job_pool[1] = 16'hFFFF;
        for (int k = 2; k < JOB_POOL_N; k++) job_pool[k] = 16'($urandom());
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 35;
        recv_idle_pct = 76;
        test_reset_directed();
        test_random_mix(130);

        send_idle_pct = 76;
        recv_idle_pct = 35;
        test_table_fill();
        test_random_mix(110);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_totals_rewrite();
        test_random_mix(110);

        wait_replies_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (replies_due.size() != 0) report_mismatch("replies never delivered", replies_due.size(), 0);

        $display("covered %0d commands, %0d replies checked, %0d total writes, peak %0d of %0d grants",
                 items_sent, replies_checked, cfg_writes, peak_held, TBL_DEPTH);
        $display("outcomes: fit %0d, short %0d, full %0d, released %0d, not found %0d, query %0d",
                 status_hits[ST_OK], status_hits[ST_SHORT], status_hits[ST_FULL],
                 status_hits[ST_RELEASED], status_hits[ST_NOT_FOUND], status_hits[ST_QUERY]);
        if (mismatches == 0) begin
            $display("[multi_resource_admission_allocator_core] OK");
        end else begin
            $display("[multi_resource_admission_allocator_core] ERROR");
        end
        $finish;
    end

endmodule
